// File: sv/ptp_hardware_clock_assert.svh
// Assertion helpers used by the clock's top-level RTL; clk and rst come from the using scope.
`ifndef PTP_HARDWARE_CLOCK_ASSERT_SVH
`define PTP_HARDWARE_CLOCK_ASSERT_SVH

// Same-cycle implication.
`define PHC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptp_hardware_clock: same-cycle check failed");

// Next-cycle implication.
`define PHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptp_hardware_clock: next-cycle check failed");

`endif

// File: sv/phc_pkg.sv
package phc_pkg;

  localparam int unsigned SEC_W         = 32;
  localparam int unsigned NS_W          = 30;
  localparam int unsigned FRACTION_BITS = 32;
  localparam int unsigned RATE_W        = 30;
  localparam int unsigned TICK_NS       = 40;

  localparam logic [NS_W-1:0] NS_PER_SEC = NS_W'(1000000000);
  localparam logic [NS_W-1:0] NS_MAX     = NS_W'(999999999);

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_ENABLE  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_ENABLE   = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_FRACTION = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_FASTER   = CFG_INDEX_W'(3);

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_READ = 2'd1,
    FUNC_LOAD = 2'd2,
    FUNC_STEP = 2'd3
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [SEC_W-1:0]  time_seconds;
    logic [NS_W-1:0]   time_nanoseconds;
    logic              step_add;
  } in_item_t;

  typedef struct packed {
    logic [SEC_W-1:0] now_seconds;
    logic [NS_W-1:0]  now_nanoseconds;
  } out_item_t;

  typedef struct packed {
    logic              clock_enable;
    logic              rate_enable;
    logic [RATE_W-1:0] rate_fraction;
    logic              rate_faster;
  } cfg_t;

  typedef struct packed {
    logic [SEC_W-1:0]         seconds;
    logic [NS_W-1:0]          nanoseconds;
    logic [FRACTION_BITS-1:0] fraction;
  } phc_time_t;

endpackage

// File: sv/phc_in_if.sv
interface phc_in_if import phc_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/phc_out_if.sv
interface phc_out_if import phc_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/phc_cfg_if.sv
interface phc_cfg_if import phc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  value;

  modport source (output valid, output index, output value, input ready);
  modport sink (input valid, input index, input value, output ready);
endinterface

// File: sv/phc_cfg_regs.sv
module phc_cfg_regs import phc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  phc_cfg_if.sink   cfg,
  output cfg_t      regs
);

  cfg_t regs_q;

  assign cfg.ready = 1'b1;
  assign regs      = regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q <= '0;
    end else if (cfg.valid) begin
      // drop writes to unknown indexes
      unique case (cfg.index)
        REG_CLOCK_ENABLE:  regs_q.clock_enable  <= cfg.value[0];
        REG_RATE_ENABLE:   regs_q.rate_enable   <= cfg.value[0];
        REG_RATE_FRACTION: regs_q.rate_fraction <= cfg.value[RATE_W-1:0];
        REG_RATE_FASTER:   regs_q.rate_faster   <= cfg.value[0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/phc_time_unit.sv
module phc_time_unit import phc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output phc_time_t now,
  output phc_time_t now_next
);

  logic [SEC_W-1:0]         clock_seconds;
  logic [NS_W-1:0]          clock_nanoseconds;
  logic [FRACTION_BITS-1:0] fraction_accumulator;

  logic [NS_W-1:0]          ns_sat;
  logic [FRACTION_BITS:0]   frac_sum;
  logic [NS_W:0]            tick_delta;
  logic [NS_W:0]            tick_ns;
  logic [NS_W:0]            add_ns;
  logic                     borrow;
  logic [NS_W:0]            sub_ns;
  logic                     tick_wrap;
  logic                     add_wrap;

  assign now.seconds     = clock_seconds;
  assign now.nanoseconds = clock_nanoseconds;
  assign now.fraction    = fraction_accumulator;

  always_comb begin
    ns_sat   = (item.time_nanoseconds > NS_MAX) ? NS_MAX : item.time_nanoseconds;
    frac_sum = {1'b0, fraction_accumulator} + (FRACTION_BITS+1)'(cfg.rate_fraction);

    // one extra nanosecond either way on a fraction carry
    tick_delta = (NS_W+1)'(TICK_NS);
    if (cfg.rate_enable && frac_sum[FRACTION_BITS]) begin
      tick_delta = cfg.rate_faster ? (NS_W+1)'(TICK_NS + 1) : (NS_W+1)'(TICK_NS - 1);
    end
    tick_ns   = {1'b0, clock_nanoseconds} + tick_delta;
    tick_wrap = (tick_ns >= {1'b0, NS_PER_SEC});

    add_ns   = {1'b0, clock_nanoseconds} + {1'b0, ns_sat};
    add_wrap = (add_ns >= {1'b0, NS_PER_SEC});

    borrow = (clock_nanoseconds < ns_sat);
    sub_ns = {1'b0, clock_nanoseconds} - {1'b0, ns_sat}
           + (borrow ? {1'b0, NS_PER_SEC} : '0);

    now_next = now;
    unique case (item.func)
      FUNC_TICK: begin
        if (cfg.clock_enable) begin
          now_next.seconds     = clock_seconds + SEC_W'(tick_wrap);
          now_next.nanoseconds = tick_wrap ? NS_W'(tick_ns - {1'b0, NS_PER_SEC})
                                           : tick_ns[NS_W-1:0];
          if (cfg.rate_enable) begin
            now_next.fraction = frac_sum[FRACTION_BITS-1:0];
          end
        end
      end
      FUNC_READ: ;
      FUNC_LOAD: begin
        now_next.seconds     = item.time_seconds;
        now_next.nanoseconds = ns_sat;
        now_next.fraction    = '0;
      end
      FUNC_STEP: begin
        if (item.step_add) begin
          now_next.seconds     = clock_seconds + item.time_seconds + SEC_W'(add_wrap);
          now_next.nanoseconds = add_wrap ? NS_W'(add_ns - {1'b0, NS_PER_SEC})
                                          : add_ns[NS_W-1:0];
        end else begin
          now_next.seconds     = clock_seconds - item.time_seconds - SEC_W'(borrow);
          now_next.nanoseconds = sub_ns[NS_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_seconds        <= '0;
      clock_nanoseconds    <= '0;
      fraction_accumulator <= '0;
    end else if (advance) begin
      clock_seconds        <= now_next.seconds;
      clock_nanoseconds    <= now_next.nanoseconds;
      fraction_accumulator <= now_next.fraction;
    end
  end

endmodule

// File: sv/ptp_hardware_clock.sv
// Channel  Role  Payload
// -------  ----  -------------------------------------------------------
// req      sink  func, time_seconds, time_nanoseconds, step_add
// rsp      src   now_seconds, now_nanoseconds
// cfg      sink  index, value (register write, always ready)
//
// Each item is taken into an input register, applied to the time registers and
// its result lands in the output register at the same edge; one item per cycle
// is sustained while rsp is ready, set by the single time update path.
// Synchronous active-high reset clears time, config registers and both valid flags.
// A stalled rsp holds its item; req keeps accepting while the input stage
// can move on, so the pipeline stops only when both stages are full.
`include "ptp_hardware_clock_assert.svh"

module ptp_hardware_clock import phc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  phc_in_if.sink   req,
  phc_out_if.source rsp,
  phc_cfg_if.sink  cfg
);

  cfg_t      regs;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      out_valid;
  out_item_t out_item;
  logic      out_free;
  logic      s1_adv;
  phc_time_t time_now;
  phc_time_t time_next;

  phc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  phc_time_unit u_time (
    .clk      (clk),
    .rst      (rst),
    .advance  (s1_adv),
    .item     (s1_item),
    .cfg      (regs),
    .now      (time_now),
    .now_next (time_next)
  );

  assign out_free  = !out_valid || rsp.ready;
  assign s1_adv    = s1_valid && out_free;
  assign req.ready = !s1_valid || s1_adv;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item <= req.data;
    end
    if (s1_adv) begin
      out_item.now_seconds     <= time_next.seconds;
      out_item.now_nanoseconds <= time_next.nanoseconds;
    end
  end

  `PHC_ASSERT_IMPLIES(a_ns_in_range, rsp.valid, rsp.data.now_nanoseconds <= NS_MAX)
  `PHC_ASSERT_IMPLIES(a_read_holds_time, s1_adv && s1_item.func == FUNC_READ, time_next == time_now)
  `PHC_ASSERT_NEXT(a_result_captured, s1_adv, out_valid && out_item.now_seconds == $past(time_next.seconds))
  `PHC_ASSERT_IMPLIES(a_full_stalls_input, s1_valid && !out_free, !req.ready)

endmodule
